// ===== src/calu_pkg.sv =====
// Package for the 8-bit accumulator ALU: operation codes, flag bit positions,
// and the operation and result item types. It has no dependencies.
package calu_pkg;

    typedef enum logic [3:0] {
        KIND_ADD   = 4'd0,
        KIND_ADC   = 4'd1,
        KIND_SUB   = 4'd2,
        KIND_SBC   = 4'd3,
        KIND_AND   = 4'd4,
        KIND_XOR   = 4'd5,
        KIND_OR    = 4'd6,
        KIND_CP    = 4'd7,
        KIND_INC   = 4'd8,
        KIND_DEC   = 4'd9,
        KIND_CPL   = 4'd10,
        KIND_ADDHL = 4'd11,
        KIND_ADDSP = 4'd12,
        KIND_INC16 = 4'd13,
        KIND_DEC16 = 4'd14
    } kind_t;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  operand_byte;
        logic [15:0] wide_base;
        logic [15:0] wide_addend;
    } op_item_t;

    typedef struct packed {
        logic [7:0]  accumulator;
        logic [3:0]  flags;
        logic [7:0]  byte_result;
        logic [15:0] wide_result;
    } res_item_t;

endpackage

// ===== src/calu_if.sv =====
// Channel interfaces of the accumulator ALU: the operation channel and the
// result channel, each with valid, ready and its payload. No dependencies.
interface calu_op_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  operand_byte;
    logic [15:0] wide_base;
    logic [15:0] wide_addend;

    modport source (output valid, output kind, output operand_byte,
                    output wide_base, output wide_addend, input ready);
    modport sink   (input valid, input kind, input operand_byte,
                    input wide_base, input wide_addend, output ready);
endinterface

interface calu_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  accumulator;
    logic [3:0]  flags;
    logic [7:0]  byte_result;
    logic [15:0] wide_result;

    modport source (output valid, output accumulator, output flags,
                    output byte_result, output wide_result, input ready);
    modport sink   (input valid, input accumulator, input flags,
                    input byte_result, input wide_result, output ready);
endinterface

// ===== src/cpu_alu_8bit_flags.sv =====
// Top level of the 8-bit accumulator ALU with flags: operation register,
// accumulator and flag state, and result register. Depends on calu_pkg,
// calu_op_if, calu_res_if and calu_core.
//
//   Channel   Dir   Beat carries
//   op        in    kind, operand_byte, wide_base, wide_addend
//   res       out   accumulator, flags, byte_result, wide_result
//
// One beat enters every cycle while the result channel does not stall; each
// operation beat yields one result beat. An op beat passes through the
// operation register, then through the datapath into the result register.
// The accumulator and flags update when the result register loads, so the
// next operation sees them without a bubble.
// Reset clears the accumulator, the flags and both valid bits.
// A stalled result holds the result register; the operation register still
// takes a beat while it is empty.
module cpu_alu_8bit_flags (
    input  logic      clk,
    input  logic      rst_n,
    calu_op_if.sink   op,
    calu_res_if.source res
);
    import calu_pkg::*;

    op_item_t  op_reg;
    logic      op_valid_reg;
    res_item_t res_reg;
    res_item_t res_next;
    logic      res_valid_reg;
    logic [7:0] acc_reg;
    logic [3:0] flag_reg;
    logic      op_take;
    logic      advance;

    assign advance = op_valid_reg && (!res_valid_reg || res.ready);
    assign op.ready = !op_valid_reg || advance;
    assign op_take = op.valid && op.ready;

    calu_core u_core (
        .item  (op_reg),
        .acc   (acc_reg),
        .flags (flag_reg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            acc_reg       <= 8'd0;
            flag_reg      <= 4'd0;
        end
        else
        begin
            if (op.ready)
            begin
                op_valid_reg <= op.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                acc_reg       <= res_next.accumulator;
                flag_reg      <= res_next.flags;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            op_reg <= '{kind: op.kind, operand_byte: op.operand_byte,
                        wide_base: op.wide_base, wide_addend: op.wide_addend};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.accumulator = res_reg.accumulator;
    assign res.flags       = res_reg.flags;
    assign res.byte_result = res_reg.byte_result;
    assign res.wide_result = res_reg.wide_result;

`ifndef SYNTH
    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (acc_reg == res_reg.accumulator) && (flag_reg == res_reg.flags))
        else $error("accumulator or flags differ from the pending result");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !op_valid_reg |-> op.ready)
        else $error("operation register empty but not ready");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result register not valid after an operation advanced");

    a_wide_step_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ((op_reg.kind == KIND_INC16) || (op_reg.kind == KIND_DEC16))
        |=> flag_reg == $past(flag_reg))
        else $error("16-bit increment or decrement changed the flags");
`endif

endmodule

// ===== src/calu_core.sv =====
// Combinational datapath of the accumulator ALU: one operation applied to the
// current accumulator and flags. Depends on calu_pkg.
module calu_core (
    input  calu_pkg::op_item_t  item,
    input  logic [7:0]          acc,
    input  logic [3:0]          flags,
    output calu_pkg::res_item_t res
);
    import calu_pkg::*;

    logic        cin;
    logic        use_cin;
    logic [8:0]  add8;
    logic [4:0]  add4;
    logic [8:0]  sub8;
    logic [4:0]  sub4;
    logic [16:0] add16;
    logic [12:0] add12;
    logic [15:0] sp_sum;
    logic [8:0]  sp_lo8;
    logic [4:0]  sp_lo4;
    logic [7:0]  b;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  and8;
    logic [7:0]  xor8;
    logic [7:0]  or8;

    assign b       = item.operand_byte;
    assign use_cin = (item.kind == KIND_ADC) || (item.kind == KIND_SBC);
    assign cin     = use_cin & flags[FLAG_C];

    assign add8   = {1'b0, acc} + {1'b0, b} + {8'd0, cin};
    assign add4   = {1'b0, acc[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign sub8   = {1'b0, acc} - {1'b0, b} - {8'd0, cin};
    assign sub4   = {1'b0, acc[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
    assign add16  = {1'b0, item.wide_base} + {1'b0, item.wide_addend};
    assign add12  = {1'b0, item.wide_base[11:0]} + {1'b0, item.wide_addend[11:0]};
    assign sp_sum = item.wide_base + {{8{b[7]}}, b};
    assign sp_lo8 = {1'b0, item.wide_base[7:0]} + {1'b0, b};
    assign sp_lo4 = {1'b0, item.wide_base[3:0]} + {1'b0, b[3:0]};
    assign inc8   = b + 8'd1;
    assign dec8   = b - 8'd1;
    assign and8   = acc & b;
    assign xor8   = acc ^ b;
    assign or8    = acc | b;

    always_comb
    begin
        res.accumulator = acc;
        res.flags       = flags;
        res.byte_result = 8'd0;
        res.wide_result = 16'd0;
        unique case (kind_t'(item.kind))
            KIND_ADD, KIND_ADC:
            begin
                res.accumulator = add8[7:0];
                res.flags = {add8[7:0] == 8'd0, 1'b0, add4[4], add8[8]};
            end
            KIND_SUB, KIND_SBC, KIND_CP:
            begin
                if (item.kind != KIND_CP)
                begin
                    res.accumulator = sub8[7:0];
                end
                res.flags = {sub8[7:0] == 8'd0, 1'b1, sub4[4], sub8[8]};
            end
            KIND_AND:
            begin
                res.accumulator = and8;
                res.flags = {and8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            KIND_XOR:
            begin
                res.accumulator = xor8;
                res.flags = {xor8 == 8'd0, 3'b000};
            end
            KIND_OR:
            begin
                res.accumulator = or8;
                res.flags = {or8 == 8'd0, 3'b000};
            end
            KIND_INC:
            begin
                res.byte_result = inc8;
                res.flags = {inc8 == 8'd0, 1'b0, b[3:0] == 4'hF, flags[FLAG_C]};
            end
            KIND_DEC:
            begin
                res.byte_result = dec8;
                res.flags = {dec8 == 8'd0, 1'b1, b[3:0] == 4'h0, flags[FLAG_C]};
            end
            KIND_CPL:
            begin
                res.accumulator = ~acc;
                res.flags = {flags[FLAG_Z], 1'b1, 1'b1, flags[FLAG_C]};
            end
            KIND_ADDHL:
            begin
                res.wide_result = add16[15:0];
                res.flags = {flags[FLAG_Z], 1'b0, add12[12], add16[16]};
            end
            KIND_ADDSP:
            begin
                res.wide_result = sp_sum;
                res.flags = {2'b00, sp_lo4[4], sp_lo8[8]};
            end
            KIND_INC16:
            begin
                res.wide_result = item.wide_base + 16'd1;
            end
            KIND_DEC16:
            begin
                res.wide_result = item.wide_base - 16'd1;
            end
            default:
            begin
                res.accumulator = acc;
            end
        endcase
    end

endmodule

// ===== tb/sv/cpu_alu_8bit_flags_tb.sv =====
// Testbench for cpu_alu_8bit_flags: directed flag edge cases, then random
// operation streams with idling on both channels, checked against a predictor.
// Depends on calu_pkg, calu_op_if, calu_res_if and the cpu_alu_8bit_flags RTL.
module cpu_alu_8bit_flags_tb;

    import calu_pkg::*;

    localparam logic [3:0] KIND_UNUSED = 4'd15;

    logic clk;
    logic rst_n;

    calu_op_if  op_ch ();
    calu_res_if res_ch ();

    cpu_alu_8bit_flags DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch.sink),
        .res   (res_ch.source)
    );

    logic [7:0]  acc_model;
    logic [3:0]  flag_model;
    res_item_t   pending_results[$];
    res_item_t   want;
    bit          src_idle;
    bit          sink_idle;
    int unsigned sink_hold;
    int unsigned ops_sent;
    int unsigned results_checked;
    int unsigned error_count;

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic res_item_t apply_alu_op(op_item_t item);
        res_item_t   r;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [3:0]  f;
        logic        cin;
        logic [8:0]  sum9;
        logic [4:0]  nib;
        logic [12:0] sum13;
        logic [16:0] sum17;
        logic [15:0] off;
        a = acc_model;
        b = item.operand_byte;
        f = flag_model;
        cin = f[FLAG_C];
        r = '0;
        case (item.kind)
            KIND_ADD, KIND_ADC: begin
                if (item.kind == KIND_ADD)
                    cin = 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                a = sum9[7:0];
                f = '0;
                f[FLAG_Z] = (a == 8'h00);
                f[FLAG_H] = nib[4];
                f[FLAG_C] = sum9[8];
            end
            KIND_SUB, KIND_SBC, KIND_CP: begin
                if (item.kind != KIND_SBC)
                    cin = 1'b0;
                sum9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
                nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
                f = '0;
                f[FLAG_Z] = (sum9[7:0] == 8'h00);
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = nib[4];
                f[FLAG_C] = sum9[8];
                if (item.kind != KIND_CP)
                    a = sum9[7:0];
            end
            KIND_AND: begin
                a = a & b;
                f = '0;
                f[FLAG_Z] = (a == 8'h00);
                f[FLAG_H] = 1'b1;
            end
            KIND_XOR, KIND_OR: begin
                a = (item.kind == KIND_XOR) ? (a ^ b) : (a | b);
                f = '0;
                f[FLAG_Z] = (a == 8'h00);
            end
            KIND_INC: begin
                r.byte_result = b + 8'd1;
                f[FLAG_Z] = (r.byte_result == 8'h00);
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = (b[3:0] == 4'hF);
            end
            KIND_DEC: begin
                r.byte_result = b - 8'd1;
                f[FLAG_Z] = (r.byte_result == 8'h00);
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = (b[3:0] == 4'h0);
            end
            KIND_CPL: begin
                a = ~a;
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = 1'b1;
            end
            KIND_ADDHL: begin
                sum17 = {1'b0, item.wide_base} + {1'b0, item.wide_addend};
                sum13 = {1'b0, item.wide_base[11:0]} + {1'b0, item.wide_addend[11:0]};
                r.wide_result = sum17[15:0];
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = sum13[12];
                f[FLAG_C] = sum17[16];
            end
            KIND_ADDSP: begin
                off = {{8{b[7]}}, b};
                r.wide_result = item.wide_base + off;
                nib = {1'b0, item.wide_base[3:0]} + {1'b0, b[3:0]};
                sum9 = {1'b0, item.wide_base[7:0]} + {1'b0, b};
                f = '0;
                f[FLAG_H] = nib[4];
                f[FLAG_C] = sum9[8];
            end
            KIND_INC16: r.wide_result = item.wide_base + 16'd1;
            KIND_DEC16: r.wide_result = item.wide_base - 16'd1;
            default: ;
        endcase
        acc_model = a;
        flag_model = f;
        r.accumulator = a;
        r.flags = f;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corner[6];
        corner = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h80, 8'h7F};
        if ($urandom_range(0, 3) == 0)
            return corner[3'($urandom_range(0, 5))];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_word();
        logic [15:0] corner[6];
        corner = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h1000, 16'h00FF, 16'h8000};
        if ($urandom_range(0, 3) == 0)
            return corner[3'($urandom_range(0, 5))];
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic op_item_t make_random_op();
        op_item_t item;
        if ($urandom_range(0, 63) == 0)
            item.kind = KIND_UNUSED;
        else
            item.kind = 4'($urandom_range(0, 14));
        item.operand_byte = pick_byte();
        item.wide_base = pick_word();
        item.wide_addend = pick_word();
        return item;
    endfunction

    task automatic send_op(input op_item_t item);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_ch.valid        <= 1'b1;
        op_ch.kind         <= item.kind;
        op_ch.operand_byte <= item.operand_byte;
        op_ch.wide_base    <= item.wide_base;
        op_ch.wide_addend  <= item.wide_addend;
        do
            @(posedge clk);
        while (op_ch.ready !== 1'b1);
        pending_results.push_back(apply_alu_op(item));
        ops_sent++;
    endtask

    task automatic send_fields(input logic [3:0] kind, input logic [7:0] b,
                               input logic [15:0] base, input logic [15:0] addend);
        op_item_t item;
        item.kind = kind;
        item.operand_byte = b;
        item.wide_base = base;
        item.wide_addend = addend;
        send_op(item);
    endtask

    task automatic run_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_op(make_random_op());
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] exp_val,
                                   input logic [15:0] got_val);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, got_val);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual acc %h flags %h",
                             $time, res_ch.accumulator, res_ch.flags);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.accumulator !== want.accumulator)
                        report_mismatch("accumulator", {8'h00, want.accumulator},
                                        {8'h00, res_ch.accumulator});
                    if (res_ch.flags !== want.flags)
                        report_mismatch("flags", {12'h000, want.flags},
                                        {12'h000, res_ch.flags});
                    if (res_ch.byte_result !== want.byte_result)
                        report_mismatch("byte_result", {8'h00, want.byte_result},
                                        {8'h00, res_ch.byte_result});
                    if (res_ch.wide_result !== want.wide_result)
                        report_mismatch("wide_result", want.wide_result, res_ch.wide_result);
                end
                results_checked++;
                sink_hold = sink_idle ? $urandom_range(0, 13) : 0;
                if (sink_hold > 0)
                begin
                    res_ch.ready <= 1'b0;
                    sink_hold = sink_hold - 1;
                end
            end
            else if (res_ch.ready !== 1'b1)
            begin
                if (sink_hold == 0)
                    res_ch.ready <= 1'b1;
                else
                    sink_hold = sink_hold - 1;
            end
        end
    end

    task automatic test_byte_arith();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        send_fields(KIND_ADD, 8'h00, 16'h0000, 16'h0000);
        send_fields(KIND_ADD, 8'h0F, 16'h0000, 16'h0000);
        send_fields(KIND_ADD, 8'h01, 16'h0000, 16'h0000);
        send_fields(KIND_ADD, 8'hF0, 16'h0000, 16'h0000);
        send_fields(KIND_ADC, 8'hFF, 16'h0000, 16'h0000);
        send_fields(KIND_SUB, 8'h01, 16'h0000, 16'h0000);
        send_fields(KIND_SBC, 8'hFE, 16'h0000, 16'h0000);
        send_fields(KIND_CP,  8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_logic_ops();
        src_idle = 1'b1;
        sink_idle = 1'b1;
        send_fields(KIND_XOR, 8'hFF, 16'h0000, 16'h0000);
        send_fields(KIND_AND, 8'h0F, 16'h0000, 16'h0000);
        send_fields(KIND_OR,  8'hF0, 16'h0000, 16'h0000);
        send_fields(KIND_CPL, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_inc_dec();
        send_fields(KIND_INC, 8'hFF, 16'h0000, 16'h0000);
        send_fields(KIND_INC, 8'h0F, 16'h0000, 16'h0000);
        send_fields(KIND_DEC, 8'h00, 16'h0000, 16'h0000);
        send_fields(KIND_DEC, 8'h01, 16'h0000, 16'h0000);
    endtask

    task automatic test_wide_ops();
        send_fields(KIND_ADDHL, 8'h00, 16'h0FFF, 16'h0001);
        send_fields(KIND_ADDHL, 8'h00, 16'hFFFF, 16'hFFFF);
        send_fields(KIND_ADDSP, 8'h01, 16'h00FF, 16'h0000);
        send_fields(KIND_ADDSP, 8'h80, 16'h0000, 16'h0000);
        send_fields(KIND_INC16, 8'h00, 16'hFFFF, 16'h0000);
        send_fields(KIND_DEC16, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_unused_kind();
        send_fields(KIND_UNUSED, 8'hA5, 16'h1234, 16'h5678);
    endtask

    task automatic test_random_mix();
        for (int unsigned blk = 0; blk < 18; blk++)
        begin
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            run_random(50);
        end
    endtask

    task automatic test_back_to_back();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        run_random(300);
    endtask

    task automatic test_source_gaps();
        src_idle = 1'b1;
        sink_idle = 1'b0;
        run_random(225);
    endtask

    task automatic test_sink_stalls();
        src_idle = 1'b0;
        sink_idle = 1'b1;
        run_random(225);
    endtask

    initial begin
        rst_n = 1'b0;
        op_ch.valid = 1'b0;
        op_ch.kind = KIND_ADD;
        op_ch.operand_byte = 8'h00;
        op_ch.wide_base = 16'h0000;
        op_ch.wide_addend = 16'h0000;
        res_ch.ready = 1'b1;
        acc_model = 8'h00;
        flag_model = 4'h0;
        src_idle = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 0;
        ops_sent = 0;
        results_checked = 0;
        error_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_arith();
        test_logic_ops();
        test_inc_dec();
        test_wide_ops();
        test_unused_kind();
        test_random_mix();
        test_back_to_back();
        test_source_gaps();
        test_sink_stalls();

        op_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d operations and checked %0d results: flag edge cases of every kind,",
                 ops_sent, results_checked);
        $display("then random streams with back-to-back beats, source gaps and sink stalls.");
        if (error_count == 0)
            $display("cpu_alu_8bit_flags_tb: done, clean");
        else
            $display("cpu_alu_8bit_flags_tb: done, errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("Timed out with %0d results still expected.", pending_results.size());
        $display("cpu_alu_8bit_flags_tb: done, errors");
        $finish;
    end

endmodule

// ===== cpu_alu_8bit_flags.f =====
src/calu_pkg.sv
src/calu_if.sv
src/calu_core.sv
src/cpu_alu_8bit_flags.sv
tb/sv/cpu_alu_8bit_flags_tb.sv
